// ----- hw/rtl/line_viewport_clip_defines.svh -----
// ----------------------------------------------------------------------------
// line_viewport_clip_defines.svh
// Assertion macros shared by the clipper RTL. Each macro expects the
// enclosing module to have signals named clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef LINE_VIEWPORT_CLIP_DEFINES_SVH
`define LINE_VIEWPORT_CLIP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside of reset.
`define LVC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("line_viewport_clip assertion failed");
// Condition must never be true outside of reset.
`define LVC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("line_viewport_clip forbidden condition seen");
`else
`define LVC_ASSERT(lbl, prop)
`define LVC_NEVER(lbl, cond)
`endif

`endif

// ----- hw/rtl/lvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lvc_pkg
// Shared types and constants of the line viewport clipper.
// ----------------------------------------------------------------------------
package lvc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned MAX_PASSES_DEF = 8;

  // Screen size registers.
  localparam int unsigned REG_BITS     = 13;
  localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd320;
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd200;

  // APB configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } lvc_reg_t;

  typedef enum logic [1:0] {
    CLIP_REJECTED = 2'd0,
    CLIP_VISIBLE  = 2'd1,
    CLIP_GAVE_UP  = 2'd2
  } lvc_status_t;

  // Status of the shared multiply/divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } lvc_md_stat_t;

endpackage

// ----- hw/rtl/lvc_if.sv -----
// ----------------------------------------------------------------------------
// lvc_if
// Valid/ready channels that carry segment items into and out of the clipper.
// ----------------------------------------------------------------------------
interface lvc_in_if
  import lvc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface lvc_out_if
  import lvc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   clip_status;
  logic signed [COORD_BITS-1:0] first_x_out;
  logic signed [COORD_BITS-1:0] first_y_out;
  logic signed [COORD_BITS-1:0] second_x_out;
  logic signed [COORD_BITS-1:0] second_y_out;

  modport source (output valid, clip_status, first_x_out, first_y_out,
                  second_x_out, second_y_out, input ready);
  modport sink   (input valid, clip_status, first_x_out, first_y_out,
                  second_x_out, second_y_out, output ready);
endinterface

// ----- hw/rtl/line_viewport_clip.sv -----
// ----------------------------------------------------------------------------
// line_viewport_clip
// Clips a line segment to a screen of programmable width and height and
// reports whether it was rejected, clipped, or abandoned at the move limit.
// ----------------------------------------------------------------------------
// Rejected, single-point, vertical and horizontal items need no clip move;
// other items take at most MAX_PASSES + 1 clip moves, each a multiply and a
// restoring divide in the shared unit.
// Throughput: one item at a time; the serial divider of the shared unit,
// one quotient bit per cycle, sets the move time.
// Reset: synchronous, active low; control clears and the screen is 320 x 200.
// ----------------------------------------------------------------------------
`include "line_viewport_clip_defines.svh"

module line_viewport_clip
  import lvc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lvc_in_if.sink                in_s,
  lvc_out_if.source             out_s,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Internal coordinates must hold both the input range and the clamp target
  // (screen size minus one), which can exceed a narrow coordinate field.
  localparam int unsigned W      = COORD_BITS;
  localparam int unsigned IW     = (W > REG_BITS + 1) ? W : REG_BITS + 1;
  localparam int unsigned CW     = IW + 1;
  localparam int unsigned PW     = 2 * W;
  localparam int unsigned SUMW   = ((IW > PW) ? IW : PW) + 2;
  localparam int unsigned PASS_W = $clog2(MAX_PASSES + 2);

  localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) <<< (W - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SELECT,
    S_RUN,
    S_APPLY,
    S_FINISH
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [REG_BITS-1:0] scr_w;
  logic [REG_BITS-1:0] scr_h;

  lvc_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (scr_w),
    .screen_height (scr_h)
  );

  // --------------------------------------------------------------------------
  // Sequencer state and working registers
  // --------------------------------------------------------------------------
  state_t                state_r;
  logic signed [IW-1:0]  x0_r, y0_r, x1_r, y1_r;
  logic signed [W:0]     dx_r, dy_r;
  logic [PASS_W-1:0]     passes_r;
  lvc_status_t           status_r;
  logic                  mv_axis_r;   // 0: x is clamped, y is adjusted
  logic                  mv_end_r;    // which endpoint moves
  logic                  mv_sub_r;    // far edge: the offset is subtracted

  logic                  out_valid_r;
  logic [1:0]            o_status_r;
  logic signed [W-1:0]   o_x0_r, o_y0_r, o_x1_r, o_y1_r;

  // Shared multiply/divide unit.
  logic                  md_start;
  logic [W-1:0]          md_a;
  logic [W-1:0]          md_b;
  logic [W-1:0]          md_d;
  logic [PW-1:0]         md_q;
  lvc_md_stat_t          md_stat;

  lvc_muldiv #(
    .COORD_BITS (COORD_BITS)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (md_start),
    .mul_a    (md_a),
    .mul_b    (md_b),
    .divisor  (md_d),
    .quotient (md_q),
    .stat     (md_stat)
  );

  // --------------------------------------------------------------------------
  // Classification of a freshly loaded segment
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] sw_c, sh_c;
  logic signed [CW-1:0] x0_c, y0_c, x1_c, y1_c;
  logic                 reject, single_pt;
  logic signed [IW-1:0] cl_y0, cl_y1, cl_x0, cl_x1;

  // Clamp one coordinate to 0 .. size-1; the target is -1 for a zero size.
  function automatic logic signed [IW-1:0] clamp_to(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] size);
    logic signed [CW-1:0] top;
    top = size - CW'(1);
    if (v < 0) begin
      clamp_to = '0;
    end else if (v >= size) begin
      clamp_to = top[IW-1:0];
    end else begin
      clamp_to = v[IW-1:0];
    end
  endfunction

  always_comb begin
    sw_c = CW'(scr_w);
    sh_c = CW'(scr_h);
    x0_c = CW'(x0_r);
    y0_c = CW'(y0_r);
    x1_c = CW'(x1_r);
    y1_c = CW'(y1_r);
    reject = (x0_c < 0 && x1_c < 0) || (y0_c < 0 && y1_c < 0) ||
             (x0_c >= sw_c && x1_c >= sw_c) || (y0_c >= sh_c && y1_c >= sh_c);
    single_pt = (x0_r == x1_r) && (y0_r == y1_r);
    cl_x0 = clamp_to(x0_c, sw_c);
    cl_x1 = clamp_to(x1_c, sw_c);
    cl_y0 = clamp_to(y0_c, sh_c);
    cl_y1 = clamp_to(y1_c, sh_c);
  end

  // --------------------------------------------------------------------------
  // Move selection: left edge, right edge, top edge, bottom edge, in that
  // order, first endpoint before second within each edge.
  // --------------------------------------------------------------------------
  logic                 need;
  logic                 sel_axis, sel_end, sel_sub;
  logic signed [CW-1:0] sel_coord, sel_size, delta, target_c;
  logic signed [W:0]    dx_mag, dy_mag;

  always_comb begin
    need     = 1'b1;
    sel_axis = 1'b0;
    sel_end  = 1'b0;
    sel_sub  = 1'b0;
    priority if (x0_c < 0) begin
      sel_end = 1'b0;
    end else if (x1_c < 0) begin
      sel_end = 1'b1;
    end else if (x0_c >= sw_c) begin
      sel_sub = 1'b1;
    end else if (x1_c >= sw_c) begin
      sel_sub = 1'b1;
      sel_end = 1'b1;
    end else if (y0_c < 0) begin
      sel_axis = 1'b1;
    end else if (y1_c < 0) begin
      sel_axis = 1'b1;
      sel_end  = 1'b1;
    end else if (y0_c >= sh_c) begin
      sel_axis = 1'b1;
      sel_sub  = 1'b1;
    end else if (y1_c >= sh_c) begin
      sel_axis = 1'b1;
      sel_sub  = 1'b1;
      sel_end  = 1'b1;
    end else begin
      need = 1'b0;
    end

    if (sel_axis) begin
      sel_coord = sel_end ? y1_c : y0_c;
      sel_size  = sh_c;
    end else begin
      sel_coord = sel_end ? x1_c : x0_c;
      sel_size  = sw_c;
    end

    // Distance past the edge; always positive and at most 2^(W-1).
    delta    = sel_sub ? (sel_coord + CW'(1) - sel_size) : -sel_coord;
    target_c = sel_sub ? (sel_size - CW'(1)) : '0;

    dx_mag = dx_r[W] ? -dx_r : dx_r;
    dy_mag = dy_r[W] ? -dy_r : dy_r;

    md_a = delta[W-1:0];
    md_b = sel_axis ? dx_mag[W-1:0] : dy_mag[W-1:0];
    md_d = sel_axis ? dy_mag[W-1:0] : dx_mag[W-1:0];

    md_start = (state_r == S_SELECT) && need && (passes_r != PASS_W'(MAX_PASSES + 1));
  end

  // --------------------------------------------------------------------------
  // Offset application with saturation to the coordinate range
  // --------------------------------------------------------------------------
  logic signed [IW-1:0]   other;
  logic signed [SUMW-1:0] q_ext, sum, sat;
  logic signed [IW-1:0]   new_coord;
  logic                   neg;

  always_comb begin
    neg   = dx_r[W] ^ dy_r[W];
    other = mv_axis_r ? (mv_end_r ? x1_r : x0_r) : (mv_end_r ? y1_r : y0_r);
    q_ext = SUMW'(md_q);
    sum   = SUMW'(other) + ((mv_sub_r ^ neg) ? -q_ext : q_ext);
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
    new_coord = IW'(signed'(sat[W-1:0]));
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      passes_r    <= '0;
      status_r    <= CLIP_VISIBLE;
      out_valid_r <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (out_valid_r && out_s.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_s.valid) begin
            x0_r    <= IW'(in_s.first_x);
            y0_r    <= IW'(in_s.first_y);
            x1_r    <= IW'(in_s.second_x);
            y1_r    <= IW'(in_s.second_y);
            dx_r    <= (W + 1)'(in_s.second_x) - (W + 1)'(in_s.first_x);
            dy_r    <= (W + 1)'(in_s.second_y) - (W + 1)'(in_s.first_y);
            state_r <= S_CLASSIFY;
          end
        end

        S_CLASSIFY: begin
          passes_r <= '0;
          status_r <= reject ? CLIP_REJECTED : CLIP_VISIBLE;
          priority if (reject) begin
            state_r  <= S_FINISH;
          end else if (single_pt) begin
            state_r <= S_FINISH;
          end else if (dx_r == '0) begin
            y0_r    <= cl_y0;
            y1_r    <= cl_y1;
            state_r <= S_FINISH;
          end else if (dy_r == '0) begin
            x0_r    <= cl_x0;
            x1_r    <= cl_x1;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_SELECT;
          end
        end

        S_SELECT: begin
          // Once MAX_PASSES moves are done the item is reported as given up,
          // though one further move is still carried out if it is due.
          priority if (!need) begin
            status_r <= (passes_r >= PASS_W'(MAX_PASSES)) ? CLIP_GAVE_UP : CLIP_VISIBLE;
            state_r  <= S_FINISH;
          end else if (passes_r == PASS_W'(MAX_PASSES + 1)) begin
            status_r <= CLIP_GAVE_UP;
            state_r  <= S_FINISH;
          end else begin
            mv_axis_r <= sel_axis;
            mv_end_r  <= sel_end;
            mv_sub_r  <= sel_sub;
            passes_r  <= passes_r + 1'b1;
            // The clamped coordinate lands on the edge right away.
            unique case ({sel_axis, sel_end})
              2'b00:   x0_r <= target_c[IW-1:0];
              2'b01:   x1_r <= target_c[IW-1:0];
              2'b10:   y0_r <= target_c[IW-1:0];
              default: y1_r <= target_c[IW-1:0];
            endcase
            state_r <= S_RUN;
          end
        end

        S_RUN: begin
          if (md_stat.done) begin
            state_r <= S_APPLY;
          end
        end

        S_APPLY: begin
          unique case ({mv_axis_r, mv_end_r})
            2'b00:   y0_r <= new_coord;
            2'b01:   y1_r <= new_coord;
            2'b10:   x0_r <= new_coord;
            default: x1_r <= new_coord;
          endcase
          state_r <= S_SELECT;
        end

        S_FINISH: begin
          if (!out_valid_r || out_s.ready) begin
            out_valid_r <= 1'b1;
            o_status_r  <= status_r;
            o_x0_r      <= x0_r[W-1:0];
            o_y0_r      <= y0_r[W-1:0];
            o_x1_r      <= x1_r[W-1:0];
            o_y1_r      <= y1_r[W-1:0];
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_s.ready         = (state_r == S_IDLE);
  assign out_s.valid        = out_valid_r;
  assign out_s.clip_status  = o_status_r;
  assign out_s.first_x_out  = o_x0_r;
  assign out_s.first_y_out  = o_y0_r;
  assign out_s.second_x_out = o_x1_r;
  assign out_s.second_y_out = o_y1_r;

  `LVC_ASSERT(a_done_only_in_run, md_stat.done |-> state_r == S_RUN)
  `LVC_NEVER(a_pass_limit, passes_r > PASS_W'(MAX_PASSES + 1))
  `LVC_ASSERT(a_gave_up_after_limit,
              (state_r == S_FINISH && status_r == CLIP_GAVE_UP) |->
              passes_r >= PASS_W'(MAX_PASSES))

endmodule

// ----- hw/rtl/lvc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lvc_cfg_regs
// APB register file holding the screen width and height.
// ----------------------------------------------------------------------------
module lvc_cfg_regs
  import lvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [REG_BITS-1:0]   screen_width,
  output logic [REG_BITS-1:0]   screen_height
);

  logic [REG_BITS-1:0] width_r;
  logic [REG_BITS-1:0] height_r;
  lvc_reg_t            reg_sel;

  assign reg_sel = lvc_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[REG_BITS-1:0];
        REG_HEIGHT: height_r <= pwdata[REG_BITS-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

// ----- hw/rtl/lvc_muldiv.sv -----
// ----------------------------------------------------------------------------
// lvc_muldiv
// Shared unsigned unit: one registered multiply, then a restoring divide
// that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "line_viewport_clip_defines.svh"

module lvc_muldiv
  import lvc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [COORD_BITS-1:0]   mul_a,
  input  logic [COORD_BITS-1:0]   mul_b,
  input  logic [COORD_BITS-1:0]   divisor,
  output logic [2*COORD_BITS-1:0] quotient,
  output lvc_md_stat_t            stat
);

  localparam int unsigned W     = COORD_BITS;
  localparam int unsigned PW    = 2 * COORD_BITS;
  localparam int unsigned CNT_W = $clog2(PW);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  md_state_t        state_r;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     d_r;
  logic [PW-1:0]    dq_r;
  logic [W-1:0]     rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [W:0]       trial;
  logic [W:0]       trial_sub;
  logic             fits;

  // One restoring step: shift the next dividend bit into the remainder.
  always_comb begin
    trial     = {rem_r, dq_r[PW-1]};
    trial_sub = trial - {1'b0, d_r};
    fits      = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (start) begin
            a_r     <= mul_a;
            b_r     <= mul_b;
            d_r     <= divisor;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          dq_r    <= a_r * b_r;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= MD_DIV;
        end
        MD_DIV: begin
          rem_r <= fits ? trial_sub[W-1:0] : trial[W-1:0];
          dq_r  <= {dq_r[PW-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PW - 1)) begin
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign quotient  = dq_r;
  assign stat.busy = (state_r != MD_IDLE);
  assign stat.done = done_r;

  `LVC_ASSERT(a_start_when_idle, start |-> !stat.busy)
  `LVC_ASSERT(a_done_after_busy, done_r |-> $past(stat.busy))
  `LVC_ASSERT(a_busy_from_start, $rose(stat.busy) |-> $past(start))

endmodule

// ----- test/line_viewport_clip_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_viewport_clip_test
// Self-checking bench for the segment clipper. Segments go in on a
// valid/ready channel with random gaps, clipped segments are checked against
// an in-bench model of the clipper, and the screen size is reprogrammed over
// APB between runs of traffic, zero and full-scale sizes included.
// ----------------------------------------------------------------------------
module line_viewport_clip_test;
  import lvc_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int PASS_LIMIT = MAX_PASSES_DEF;
  localparam longint COORD_HI = (longint'(1) << (CB - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint unsigned OFFSET_CAP  = 64'd1 << 62;
  localparam longint unsigned SCREEN_MASK = (64'd1 << REG_BITS) - 1;
  localparam int PHASE_COUNT     = 10;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int LONG_HOLD       = 400;

  typedef struct packed {
    logic signed [CB-1:0] x0;
    logic signed [CB-1:0] y0;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
  } segment_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [CB-1:0] x0;
    logic signed [CB-1:0] y0;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
  } clip_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lvc_in_if  #(.COORD_BITS(CB)) seg_in  ();
  lvc_out_if #(.COORD_BITS(CB)) seg_out ();

  line_viewport_clip #(
    .COORD_BITS(CB),
    .MAX_PASSES(PASS_LIMIT)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (seg_in),
    .out_s  (seg_out),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Segments waiting to be offered, and the clipped segments we expect back
  // in order. The clipper handles one segment at a time, so results return in
  // the order the segments were accepted.
  segment_t     segments_to_send [$];
  clip_result_t clips_due [$];

  // Shadow copy of the screen size registers, as the clipper sees them.
  longint screen_w;
  longint screen_h;

  // Working endpoints of the segment that the model is clipping.
  longint work_x [2];
  longint work_y [2];

  int  mismatches;
  int  segments_offered;
  int  segments_accepted;
  int  results_checked;
  int  screens_used;
  int  status_tally [4];
  bit  gaps_on;
  int  send_gap;
  int  recv_stall;
  int  hold_cycles_left;
  int  hold_cycles_spent;
  bit  long_hold_done;

  segment_t     next_seg;
  clip_result_t got;
  clip_result_t want;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Clipper model
  // --------------------------------------------------------------------------

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Exact trunc(a*b/d), rounded toward zero. Operands stay below 2^18 in
  // size, so the product always fits in 64 bits; the cap at 2^62 is kept for
  // completeness.
  function automatic longint scaled_offset(input longint a, input longint b,
                                           input longint d);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned ud;
    longint unsigned q;
    bit              neg;
    ua = longint'(a < 0 ? -a : a);
    ub = longint'(b < 0 ? -b : b);
    ud = longint'(d < 0 ? -d : d);
    if (ud == 0) return 0;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    q = ua * ub / ud;
    if (q > OFFSET_CAP) q = OFFSET_CAP;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Moves one endpoint onto an edge. The order is fixed: left edge, then
  // right, then top, then bottom, first endpoint before second within each.
  // Returns 0 when both endpoints already lie on the screen.
  function automatic bit move_to_edge(input longint dx, input longint dy);
    int k;
    for (k = 0; k < 2; k++)
      if (work_x[k] < 0) begin
        work_y[k] = clamp_coord(work_y[k] + scaled_offset(-work_x[k], dy, dx));
        work_x[k] = 0;
        return 1'b1;
      end
    for (k = 0; k < 2; k++)
      if (work_x[k] >= screen_w) begin
        work_y[k] = clamp_coord(work_y[k] -
                                scaled_offset(work_x[k] + 1 - screen_w, dy, dx));
        work_x[k] = screen_w - 1;
        return 1'b1;
      end
    for (k = 0; k < 2; k++)
      if (work_y[k] < 0) begin
        work_x[k] = clamp_coord(work_x[k] + scaled_offset(-work_y[k], dx, dy));
        work_y[k] = 0;
        return 1'b1;
      end
    for (k = 0; k < 2; k++)
      if (work_y[k] >= screen_h) begin
        work_x[k] = clamp_coord(work_x[k] -
                                scaled_offset(work_y[k] + 1 - screen_h, dx, dy));
        work_y[k] = screen_h - 1;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic longint clamp_to_screen(input longint v, input longint size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  function automatic clip_result_t clip_segment(input segment_t s);
    clip_result_t r;
    longint       dx;
    longint       dy;
    int           passes;
    bit           moved;
    int           k;
    work_x[0] = longint'($signed(s.x0));
    work_y[0] = longint'($signed(s.y0));
    work_x[1] = longint'($signed(s.x1));
    work_y[1] = longint'($signed(s.y1));
    r.status = CLIP_VISIBLE;
    if ((work_x[0] < 0 && work_x[1] < 0) || (work_y[0] < 0 && work_y[1] < 0) ||
        (work_x[0] >= screen_w && work_x[1] >= screen_w) ||
        (work_y[0] >= screen_h && work_y[1] >= screen_h)) begin
      r.status = CLIP_REJECTED;
    end else if (!(work_x[0] == work_x[1] && work_y[0] == work_y[1])) begin
      dx = work_x[1] - work_x[0];
      dy = work_y[1] - work_y[0];
      if (dx == 0) begin
        for (k = 0; k < 2; k++) work_y[k] = clamp_to_screen(work_y[k], screen_h);
      end else if (dy == 0) begin
        for (k = 0; k < 2; k++) work_x[k] = clamp_to_screen(work_x[k], screen_w);
      end else begin
        passes = 0;
        moved  = 1'b1;
        while (passes < PASS_LIMIT && moved) begin
          moved = move_to_edge(dx, dy);
          if (moved) passes++;
        end
        // Once the pass limit is used up the clipper still makes one more
        // move if one is due, and reports that it gave up either way.
        if (moved) begin
          void'(move_to_edge(dx, dy));
          r.status = CLIP_GAVE_UP;
        end
      end
    end
    r.x0 = CB'(work_x[0]);
    r.y0 = CB'(work_y[0]);
    r.x1 = CB'(work_x[1]);
    r.y1 = CB'(work_y[1]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic longint pick_between(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // Idle lengths from three ranges: mostly the shortest, now and then the longest.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  // Most segments fall in a window a little larger than the screen so that
  // they need real clipping. The rest cover far endpoints, lines that cut
  // across a corner of the screen or pass it, vertical and horizontal lines, single
  // points and the full coordinate range.
  function automatic segment_t random_segment();
    segment_t s;
    longint   lo_x;
    longint   hi_x;
    longint   lo_y;
    longint   hi_y;
    longint   cx;
    longint   cy;
    longint   sx;
    longint   sy;
    longint   v;
    int       kind;
    lo_x = -(screen_w / 2) - 40;
    hi_x = screen_w + screen_w / 2 + 40;
    lo_y = -(screen_h / 2) - 40;
    hi_y = screen_h + screen_h / 2 + 40;
    kind = $urandom_range(0, 99);
    s.x0 = CB'(pick_between(lo_x, hi_x));
    s.y0 = CB'(pick_between(lo_y, hi_y));
    s.x1 = CB'(pick_between(lo_x, hi_x));
    s.y1 = CB'(pick_between(lo_y, hi_y));
    if (kind < 55) begin
      // Window endpoints as drawn above.
    end else if (kind < 65) begin
      if ($urandom_range(0, 1) == 1) begin
        s.x1 = CB'($urandom);
        s.y1 = CB'($urandom);
      end else begin
        s.x0 = CB'($urandom);
        s.y0 = CB'($urandom);
      end
    end else if (kind < 73) begin
      // One end beside the corner, the other above or below it.
      sx = ($urandom_range(0, 1) == 1) ? 1 : -1;
      sy = ($urandom_range(0, 1) == 1) ? 1 : -1;
      cx = (sx > 0) ? screen_w - 1 : 0;
      cy = (sy > 0) ? screen_h - 1 : 0;
      s.x0 = CB'(cx + sx * pick_between(1, 60));
      s.y0 = CB'(cy - sy * pick_between(0, 60));
      s.x1 = CB'(cx - sx * pick_between(0, 60));
      s.y1 = CB'(cy + sy * pick_between(1, 60));
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) == 1) s.x1 = s.x0;
      else s.y1 = s.y0;
    end else if (kind < 83) begin
      s.x1 = s.x0;
      s.y1 = s.y0;
    end else begin
      v = longint'($urandom);
      s.x0 = CB'(v);
      s.y0 = CB'(v >> CB);
      v = longint'($urandom);
      s.x1 = CB'(v);
      s.y1 = CB'(v >> CB);
    end
    return s;
  endfunction

  task automatic queue_segment(input int x0, input int y0, input int x1, input int y1);
    segment_t s;
    s.x0 = CB'(x0);
    s.y0 = CB'(y0);
    s.x1 = CB'(x1);
    s.y1 = CB'(y1);
    segments_to_send.push_back(s);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // APB configuration access
  // --------------------------------------------------------------------------

  // A setup phase, then an access phase; the access completes at the rising
  // edge where pready is high, which is also where read data is taken.
  task automatic apb_transfer(input bit is_write, input lvc_reg_t r,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= CFG_ADDR_W'({r, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input lvc_reg_t r, input longint value);
    logic [CFG_DATA_W-1:0] rdata;
    apb_transfer(1'b0, r, '0, rdata);
    if (rdata !== CFG_DATA_W'(value))
      flag_mismatch($sformatf("register %s reads %0d, expected %0d", r.name(), rdata, value));
  endtask

  // Writes a screen size with random junk above the register width, which
  // the clipper must drop, and reads it back.
  task automatic program_screen(input lvc_reg_t r, input int unsigned value);
    logic [CFG_DATA_W-1:0] rdata;
    longint                kept;
    kept = longint'(value) & longint'(SCREEN_MASK);
    apb_transfer(1'b1, r, (CFG_DATA_W'($urandom) << REG_BITS) | CFG_DATA_W'(kept), rdata);
    if (r == REG_WIDTH) screen_w = kept;
    else screen_h = kept;
    check_register(r, kept);
  endtask

  // Returns once every queued segment has been sent and clipped.
  task automatic wait_until_drained();
    while (!(segments_to_send.size() == 0 && !seg_in.valid && clips_due.size() == 0))
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers the queued segments, holding each one until accepted, and
  // leaves random gaps between items when gaps are enabled.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (seg_in.valid && segments_accepted != segments_offered) begin
      // The offered item has not been taken yet; keep it on the bus.
    end else if (send_gap > 0) begin
      send_gap--;
      seg_in.valid <= 1'b0;
    end else if (segments_to_send.size() != 0) begin
      next_seg = segments_to_send.pop_front();
      seg_in.first_x  <= next_seg.x0;
      seg_in.first_y  <= next_seg.y0;
      seg_in.second_x <= next_seg.x1;
      seg_in.second_y <= next_seg.y1;
      seg_in.valid    <= 1'b1;
      segments_offered++;
      if (gaps_on && $urandom_range(0, 99) < 35) send_gap = gap_len();
    end else begin
      seg_in.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random short stalls, plus one long hold-off while the sender
  // still has plenty queued, so the clipper fills up and stops taking input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles_left > 0) begin
      hold_cycles_left--;
      hold_cycles_spent++;
      seg_out.ready <= 1'b0;
    end else if (!long_hold_done && segments_accepted >= 300 &&
                 segments_to_send.size() > 8) begin
      long_hold_done    = 1'b1;
      hold_cycles_left  = LONG_HOLD - 1;
      hold_cycles_spent = 1;
      seg_out.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      seg_out.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 8) begin
      recv_stall = gap_len() - 1;
      seg_out.ready <= 1'b0;
    end else begin
      seg_out.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each returned segment against the oldest expectation,
  // then records a newly accepted input segment with its predicted clip.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (seg_out.valid && seg_out.ready) begin
        got = {seg_out.clip_status, seg_out.first_x_out, seg_out.first_y_out,
               seg_out.second_x_out, seg_out.second_y_out};
        if (clips_due.size() == 0) begin
          flag_mismatch($sformatf("result status %0d (%0d,%0d)-(%0d,%0d) with nothing pending",
                                  got.status, got.x0, got.y0, got.x1, got.y1));
        end else begin
          want = clips_due.pop_front();
          status_tally[want.status]++;
          if (got !== want)
            flag_mismatch($sformatf({"item %0d: expected status %0d (%0d,%0d)-(%0d,%0d),",
                                     " got status %0d (%0d,%0d)-(%0d,%0d)"},
                                    results_checked, want.status, want.x0, want.y0,
                                    want.x1, want.y1, got.status, got.x0, got.y0,
                                    got.x1, got.y1));
          results_checked++;
        end
      end
      if (seg_in.valid && seg_in.ready) begin
        clips_due.push_back(clip_segment(segment_t'({seg_in.first_x, seg_in.first_y,
                                                     seg_in.second_x, seg_in.second_y})));
        segments_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned plan_w [PHASE_COUNT];
    int unsigned plan_h [PHASE_COUNT];
    int          p;
    int          n;

    // Screen sizes for the random phases: square and lopsided extremes, a
    // zero size on each axis and the largest register value. The last two are
    // drawn at random.
    plan_w = '{640, 1, 4096, 1, 4096, 8191, 0, 100, 0, 0};
    plan_h = '{480, 1, 4096, 4096, 1, 8191, 37, 0, 0, 0};

    clk               = 1'b0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    seg_in.valid      = 1'b0;
    seg_in.first_x    = '0;
    seg_in.first_y    = '0;
    seg_in.second_x   = '0;
    seg_in.second_y   = '0;
    seg_out.ready     = 1'b0;
    mismatches        = 0;
    segments_offered  = 0;
    segments_accepted = 0;
    results_checked   = 0;
    screens_used      = 1;
    status_tally      = '{0, 0, 0, 0};
    gaps_on           = 1'b1;
    send_gap          = 0;
    recv_stall        = 0;
    hold_cycles_left  = 0;
    hold_cycles_spent = 0;
    long_hold_done    = 1'b0;
    screen_w          = longint'(WIDTH_RESET);
    screen_h          = longint'(HEIGHT_RESET);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // The registers must come out of reset as a 320 by 200 screen.
    check_register(REG_WIDTH, screen_w);
    check_register(REG_HEIGHT, screen_h);

    // Directed segments on the reset screen.
    queue_segment(0, 0, 319, 199);                 // fully visible diagonal
    queue_segment(-32768, -32768, 32767, 32767);   // coordinate extremes
    queue_segment(32767, -32768, -32768, 32767);
    queue_segment(-5, 10, -1, 150);                // both left of the screen
    queue_segment(10, -5, 300, -1);                // both above
    queue_segment(320, 10, 400, 150);              // both right
    queue_segment(10, 200, 300, 32767);            // both below
    queue_segment(100, 100, 100, 100);             // single visible point
    queue_segment(-32768, -32768, -32768, -32768); // single point off screen
    queue_segment(0, 0, 0, 0);
    queue_segment(10, -50, 10, 500);               // vertical, clamped in y
    queue_segment(-100, 50, 1000, 50);             // horizontal, clamped in x
    queue_segment(-10, 5, 5, -10);                 // misses the top-left corner
    queue_segment(330, 195, 310, 215);             // misses the bottom-right corner
    queue_segment(-50, -30, 400, 260);             // clipped at both ends
    queue_segment(400, -20, -30, 230);             // negative slope
    queue_segment(319, 0, 0, 199);
    queue_segment(-1, 0, 320, 199);                // each end one step outside
    queue_segment(0, -1, 319, 200);
    queue_segment(-3, 10, 4, 0);                   // offset truncates toward zero
    queue_segment(32767, 100, -32768, 101);        // long and shallow
    queue_segment(5, -32768, 6, 32767);            // long and steep
    wait_until_drained();

    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p >= PHASE_COUNT - 2) begin
        plan_w[p] = $urandom_range(1, 4096);
        plan_h[p] = $urandom_range(1, 4096);
      end
      program_screen(REG_WIDTH, plan_w[p]);
      program_screen(REG_HEIGHT, plan_h[p]);
      screens_used++;
      // About one phase in four runs with both sides at full rate.
      gaps_on = ($urandom_range(0, 3) != 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++) segments_to_send.push_back(random_segment());
      wait_until_drained();
    end

    // Any stray result from the clipper would show up in this window.
    repeat (400) @(negedge clk);

    $display("Clipped %0d segments on %0d screen sizes (zero and full-scale included):",
             results_checked, screens_used);
    $display("%0d rejected, %0d visible, %0d stopped at the move limit; output held %0d cycles.",
             status_tally[CLIP_REJECTED], status_tally[CLIP_VISIBLE],
             status_tally[CLIP_GAVE_UP], hold_cycles_spent);
    if (mismatches == 0) begin
      $display("line_viewport_clip_test: PASS");
    end else begin
      $display("line_viewport_clip_test: FAIL");
    end
    $finish;
  end

  // A correct run, with the longest gaps on both sides, the long hold-off and
  // the register accesses, ends before this watchdog's hard stop fires.
  initial begin
    #40_000_000;
    $display("line_viewport_clip_test: FAIL");
    $finish;
  end

endmodule
